>>> design/dtc_pkg.sv
// shared types and constants for the trimmed time-of-day clock
// no dependencies; every other design file refers to this package by scoped names
package dtc_pkg;

   // accumulator fraction width default of the top-level parameter
   localparam int FRACTION_BITS_DEF = 16;

   // field widths
   localparam int INC_W    = 16;
   localparam int TPS_W    = 8;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PHASE_INCREMENT  = 2'd0,
      CSR_TICKS_PER_SECOND = 2'd1,
      CSR_HOUR_MAX         = 2'd2,
      CSR_HOUR_MIN         = 2'd3
   } csr_index_type;

   // register reset values
   localparam logic [INC_W-1:0]  PHASE_INCREMENT_RST  = 16'd32768;
   localparam logic [TPS_W-1:0]  TICKS_PER_SECOND_RST = 8'd100;
   localparam logic [HOUR_W-1:0] HOUR_MAX_RST         = 5'd23;
   localparam logic [HOUR_W-1:0] HOUR_MIN_RST         = 5'd0;

   // last value of a minute or second count before it rolls over
   localparam int LAST_MINUTE_OR_SECOND = 59;

   typedef enum logic [0:0] {
      OP_TICK = 1'b0,
      OP_SET  = 1'b1
   } opcode_type;

   // events raised by the sub-second stage on a tick
   typedef struct packed {
      logic half;
      logic second;
   } subsec_event_type;

endpackage

>>> design/dtc_req_if.sv
// request channel of the trimmed time-of-day clock: tick or set-time items
// depends on dtc_pkg
interface dtc_req_if;
   logic                              valid;
   logic                              ready;
   dtc_pkg::opcode_type               opcode;
   logic [dtc_pkg::HOUR_W-1:0]        new_hour;
   logic [dtc_pkg::MINUTE_W-1:0]      new_minute;
   logic [dtc_pkg::SECOND_W-1:0]      new_second;

   modport source (output valid, opcode, new_hour, new_minute, new_second, input ready);
   modport sink   (input valid, opcode, new_hour, new_minute, new_second, output ready);
endinterface

>>> design/dtc_rsp_if.sv
// response channel of the trimmed time-of-day clock: time and event bits
// depends on dtc_pkg
interface dtc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [dtc_pkg::HOUR_W-1:0]        hour_now;
   logic [dtc_pkg::MINUTE_W-1:0]      minute_now;
   logic [dtc_pkg::SECOND_W-1:0]      second_now;
   logic                              tick_event;
   logic                              half_second_event;
   logic                              second_event;

   modport source (output valid, hour_now, minute_now, second_now, tick_event,
                   half_second_event, second_event, input ready);
   modport sink   (input valid, hour_now, minute_now, second_now, tick_event,
                   half_second_event, second_event, output ready);
endinterface

>>> design/dds_trimmed_time_of_day_clock.sv
// top level of the trimmed time-of-day clock: handshake, time registers, result register
// depends on dtc_pkg, dtc_req_if, dtc_rsp_if and dtc_subsec
//
// Real-time clock advanced by timer-tick transfers on the request channel. Each tick adds
// phase_increment to a FRACTION_BITS wide phase accumulator; every carry out of the
// fraction steps a sub-second down-counter that reloads to ticks_per_second-1 and, on
// reaching zero, advances seconds, minutes and hours (hours wrap from hour_max to
// hour_min, checked on each seconds rollover). A set-time transfer loads hours, minutes
// and seconds and reloads the sub-second counter. Each request yields exactly one
// response carrying the time after the item plus tick, half-second and second event
// bits. Throughput is one item per clock: the whole update is one add and a few compares
// between the state registers and the response register, and the response shows up the
// cycle after the request transfer. The response register lets a new request transfer
// in while the last response is being taken; only a stalled, full response register
// holds off requests. Configuration registers are written through the csr_ port and
// take effect on the next item. No clearing pass after reset.
module dds_trimmed_time_of_day_clock #(
   parameter int FRACTION_BITS = dtc_pkg::FRACTION_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   dtc_req_if.sink                             req_bus,
   dtc_rsp_if.source                           rsp_bus,
   input  logic                                csr_wr_en,
   input  logic [dtc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dtc_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   localparam int SEC_INC_W  = dtc_pkg::SECOND_W + 1;
   localparam int MIN_INC_W  = dtc_pkg::MINUTE_W + 1;
   localparam int HOUR_INC_W = dtc_pkg::HOUR_W + 1;

   // configuration registers
   logic [dtc_pkg::INC_W-1:0]     phase_increment_ff;
   logic [dtc_pkg::TPS_W-1:0]     ticks_per_second_ff;
   logic [dtc_pkg::HOUR_W-1:0]    hour_max_ff;
   logic [dtc_pkg::HOUR_W-1:0]    hour_min_ff;

   // time of day
   logic [dtc_pkg::HOUR_W-1:0]    hour_ff, hour_in;
   logic [dtc_pkg::MINUTE_W-1:0]  minute_ff, minute_in;
   logic [dtc_pkg::SECOND_W-1:0]  second_ff, second_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [dtc_pkg::HOUR_W-1:0]    hour_now_ff;
   logic [dtc_pkg::MINUTE_W-1:0]  minute_now_ff;
   logic [dtc_pkg::SECOND_W-1:0]  second_now_ff;
   logic                          tick_ev_ff;
   logic                          half_ev_ff;
   logic                          second_ev_ff;

   logic                          transfer;
   logic                          is_set;
   logic                          advance;
   logic                          load;
   dtc_pkg::subsec_event_type     events;

   // full-precision increments so out-of-range loaded values still roll over
   logic [SEC_INC_W-1:0]          sec_inc;
   logic [MIN_INC_W-1:0]          min_inc;
   logic [HOUR_INC_W-1:0]         hour_inc;

   // accept while the response register is empty or being drained
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign transfer      = req_bus.valid && req_bus.ready;
   assign is_set        = (req_bus.opcode == dtc_pkg::OP_SET);
   assign advance       = transfer && !is_set;
   assign load          = transfer && is_set;

   dtc_subsec #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_subsec (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .load             (load),
      .phase_increment  (phase_increment_ff),
      .ticks_per_second (ticks_per_second_ff),
      .events           (events)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_increment_ff  <= dtc_pkg::PHASE_INCREMENT_RST;
         ticks_per_second_ff <= dtc_pkg::TICKS_PER_SECOND_RST;
         hour_max_ff         <= dtc_pkg::HOUR_MAX_RST;
         hour_min_ff         <= dtc_pkg::HOUR_MIN_RST;
      end else if (csr_wr_en) begin
         case (dtc_pkg::csr_index_type'(csr_index))
            dtc_pkg::CSR_PHASE_INCREMENT: begin
               phase_increment_ff <= csr_wr_data[dtc_pkg::INC_W-1:0];
            end
            dtc_pkg::CSR_TICKS_PER_SECOND: begin
               ticks_per_second_ff <= csr_wr_data[dtc_pkg::TPS_W-1:0];
            end
            dtc_pkg::CSR_HOUR_MAX: begin
               hour_max_ff <= csr_wr_data[dtc_pkg::HOUR_W-1:0];
            end
            dtc_pkg::CSR_HOUR_MIN: begin
               hour_min_ff <= csr_wr_data[dtc_pkg::HOUR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // next time of day: set-time load or seconds carry chain
   always_comb begin
      sec_inc  = SEC_INC_W'(second_ff) + SEC_INC_W'(1);
      min_inc  = MIN_INC_W'(minute_ff) + MIN_INC_W'(1);
      hour_inc = HOUR_INC_W'(hour_ff);

      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;

      if (load) begin
         hour_in   = req_bus.new_hour;
         minute_in = req_bus.new_minute;
         second_in = req_bus.new_second;
      end else if (advance && events.second) begin
         if (sec_inc > SEC_INC_W'(dtc_pkg::LAST_MINUTE_OR_SECOND)) begin
            second_in = '0;
            // minute carry first, then the hour wrap check
            if (min_inc > MIN_INC_W'(dtc_pkg::LAST_MINUTE_OR_SECOND)) begin
               min_inc  = '0;
               hour_inc = HOUR_INC_W'(hour_ff) + HOUR_INC_W'(1);
            end
            if (hour_inc > HOUR_INC_W'(hour_max_ff)) begin
               hour_inc = HOUR_INC_W'(hour_min_ff);
            end
            minute_in = min_inc[dtc_pkg::MINUTE_W-1:0];
            hour_in   = hour_inc[dtc_pkg::HOUR_W-1:0];
         end else begin
            second_in = sec_inc[dtc_pkg::SECOND_W-1:0];
         end
      end
   end

   // response valid holds until the sink takes it
   always_comb begin
      if (transfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_ff      <= '0;
         minute_ff    <= '0;
         second_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hour_ff      <= hour_in;
         minute_ff    <= minute_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      if (transfer) begin
         hour_now_ff   <= hour_in;
         minute_now_ff <= minute_in;
         second_now_ff <= second_in;
         tick_ev_ff    <= !is_set;
         half_ev_ff    <= !is_set && events.half;
         second_ev_ff  <= !is_set && events.second;
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.hour_now          = hour_now_ff;
   assign rsp_bus.minute_now        = minute_now_ff;
   assign rsp_bus.second_now        = second_now_ff;
   assign rsp_bus.tick_event        = tick_ev_ff;
   assign rsp_bus.half_second_event = half_ev_ff;
   assign rsp_bus.second_event      = second_ev_ff;

endmodule

>>> design/dtc_subsec.sv
// phase accumulator and sub-second down-counter of the trimmed clock
// depends on dtc_pkg
module dtc_subsec #(
   parameter int FRACTION_BITS = dtc_pkg::FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          load,
   input  logic [dtc_pkg::INC_W-1:0]     phase_increment,
   input  logic [dtc_pkg::TPS_W-1:0]     ticks_per_second,
   output dtc_pkg::subsec_event_type     events
);

   localparam int SUM_W = ((FRACTION_BITS > dtc_pkg::INC_W) ? FRACTION_BITS
                                                            : dtc_pkg::INC_W) + 1;

   logic [FRACTION_BITS-1:0]      acc_ff, acc_in;
   logic [dtc_pkg::TPS_W-1:0]     count_ff, count_in;
   logic [SUM_W-1:0]              sum;
   logic                          carry;
   logic [dtc_pkg::TPS_W-1:0]     reload;
   logic [dtc_pkg::TPS_W-1:0]     half_point;

   always_comb begin
      sum        = SUM_W'(acc_ff) + SUM_W'(phase_increment);
      carry      = sum[FRACTION_BITS];
      reload     = ticks_per_second - dtc_pkg::TPS_W'(1);
      half_point = ticks_per_second >> 1;

      // only the carry bit counts, higher sum bits fall away
      events.half   = carry && (count_ff != '0) && (count_ff == half_point);
      events.second = carry && (count_ff == '0);

      acc_in   = acc_ff;
      count_in = count_ff;
      if (load) begin
         count_in = reload;
      end else if (advance) begin
         acc_in = sum[FRACTION_BITS-1:0];
         if (carry) begin
            count_in = (count_ff != '0) ? count_ff - dtc_pkg::TPS_W'(1) : reload;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         count_ff <= '0;
      end else begin
         acc_ff   <= acc_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> design/dtc_checker.sv
// port-level assertions for the trimmed time-of-day clock and the bind that attaches them
// depends on dtc_pkg and dds_trimmed_time_of_day_clock
module dtc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input dtc_pkg::opcode_type               req_opcode,
   input logic [dtc_pkg::HOUR_W-1:0]        req_new_hour,
   input logic [dtc_pkg::MINUTE_W-1:0]      req_new_minute,
   input logic [dtc_pkg::SECOND_W-1:0]      req_new_second,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [dtc_pkg::HOUR_W-1:0]        rsp_hour_now,
   input logic [dtc_pkg::MINUTE_W-1:0]      rsp_minute_now,
   input logic [dtc_pkg::SECOND_W-1:0]      rsp_second_now,
   input logic                              rsp_tick_event,
   input logic                              rsp_half_second_event,
   input logic                              rsp_second_event
);

   // a stalled response holds its valid, time, tick and second event bits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hour_now)
         && $stable(rsp_minute_now) && $stable(rsp_second_now)
         && $stable(rsp_tick_event) && $stable(rsp_second_event))
      else $error("stalled response changed");

   // set time shows the loaded time with no events on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == dtc_pkg::OP_SET
      |=> rsp_valid && rsp_hour_now == $past(req_new_hour)
         && rsp_minute_now == $past(req_new_minute)
         && rsp_second_now == $past(req_new_second)
         && !rsp_tick_event && !rsp_half_second_event && !rsp_second_event)
      else $error("set-time response wrong");

   // a tick transfer gives a tick response on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == dtc_pkg::OP_TICK
      |=> rsp_valid && rsp_tick_event)
      else $error("tick response missing");

   // half second and full second come only from ticks and never together
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_half_second_event || rsp_second_event)
      |-> rsp_tick_event && !(rsp_half_second_event && rsp_second_event))
      else $error("inconsistent event bits");

   // no request is taken while a response is stuck
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken over a stalled response");

endmodule

bind dds_trimmed_time_of_day_clock dtc_checker u_dtc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_bus.valid),
   .req_ready             (req_bus.ready),
   .req_opcode            (req_bus.opcode),
   .req_new_hour          (req_bus.new_hour),
   .req_new_minute        (req_bus.new_minute),
   .req_new_second        (req_bus.new_second),
   .rsp_valid             (rsp_bus.valid),
   .rsp_ready             (rsp_bus.ready),
   .rsp_hour_now          (rsp_bus.hour_now),
   .rsp_minute_now        (rsp_bus.minute_now),
   .rsp_second_now        (rsp_bus.second_now),
   .rsp_tick_event        (rsp_bus.tick_event),
   .rsp_half_second_event (rsp_bus.half_second_event),
   .rsp_second_event      (rsp_bus.second_event)
);
